// ===== hdl/bcd_pkg.sv =====
package bcd_pkg;

    localparam int DEF_CHANNELS        = 16;
    localparam int DEF_SAMPLE_BITS     = 24;
    localparam int DEF_FRAME_BYTES     = 64;
    localparam int DEF_MAX_RING_FRAMES = 16384;

    localparam int BYTE_W       = 8;
    localparam int SAMPLE_W     = 32;
    localparam int SAMPLE_SHIFT = 8;
    localparam int CHANNEL_W    = 4;
    localparam int RING_POS_W   = 14;
    localparam int PERIOD_CNT_W = 13;
    localparam int RING_CFG_W   = 15;
    localparam int PERIOD_CFG_W = 14;
    localparam int CFG_DATA_W   = 15;
    localparam int CFG_INDEX_W  = 2;
    localparam int PERIOD_MAX   = 8192;

    localparam logic ACT_DATA    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CAPTURE_ENABLE = 2'd0,
        CFG_RING_FRAMES    = 2'd1,
        CFG_PERIOD_FRAMES  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample;
        logic [CHANNEL_W-1:0]  channel;
        logic [RING_POS_W-1:0] ring_position;
        logic                  period_done;
        logic                  last;
    } out_item_t;

    // per-item control from the input handshake
    typedef struct packed {
        logic restart;
        logic shift;
        logic frame_end;
    } ctl_t;

    typedef struct packed {
        logic [RING_POS_W-1:0] ring_position;
        logic                  period_done;
    } frame_info_t;

endpackage

// ===== hdl/bcd_shift.sv =====
module bcd_shift #(
    parameter int CHANNELS    = bcd_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = bcd_pkg::DEF_SAMPLE_BITS,
    parameter int FRAME_BYTES = bcd_pkg::DEF_FRAME_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bcd_pkg::ctl_t               ctl,
    input  logic [bcd_pkg::BYTE_W-1:0]  data_byte,
    output logic                        last_byte,
    output logic [SAMPLE_BITS-1:0]      shift_next [CHANNELS]
);
    import bcd_pkg::*;

    localparam int          BPOS_W = $clog2(FRAME_BYTES);
    localparam logic [31:0] HALF   = 32'(FRAME_BYTES / 2);
    localparam logic [31:0] SBITS  = 32'(SAMPLE_BITS);

    logic [BPOS_W-1:0]      byte_pos_reg;
    logic [BPOS_W-1:0]      byte_pos_next;
    logic [SAMPLE_BITS-1:0] shift_reg [CHANNELS];
    logic [31:0]            pos_w;
    logic                   even_hit;
    logic                   odd_hit;

    assign pos_w     = 32'(byte_pos_reg);
    assign even_hit  = (pos_w < HALF) && (pos_w < SBITS);
    assign odd_hit   = (pos_w >= HALF) && ((pos_w - HALF) < SBITS);
    assign last_byte = (byte_pos_reg == BPOS_W'(FRAME_BYTES - 1));

    always_comb begin
        if (ctl.restart) begin
            byte_pos_next = '0;
        end else if (ctl.shift) begin
            byte_pos_next = last_byte ? '0 : byte_pos_reg + BPOS_W'(1);
        end else begin
            byte_pos_next = byte_pos_reg;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic hit;
        assign hit = ((c % 2) == 0) ? even_hit : odd_hit;
        assign shift_next[c] = hit ? {shift_reg[c][SAMPLE_BITS-2:0], data_byte[c / 2]}
                                   : shift_reg[c];

        always_ff @(posedge aclk) begin
            if (!aresetn || ctl.restart) begin
                shift_reg[c] <= '0;
            end else if (ctl.shift && hit) begin
                shift_reg[c] <= shift_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg <= '0;
        end else begin
            byte_pos_reg <= byte_pos_next;
        end
    end

endmodule

// ===== hdl/bcd_frame.sv =====
module bcd_frame #(
    parameter int MAX_RING_FRAMES = bcd_pkg::DEF_MAX_RING_FRAMES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bcd_pkg::ctl_t                     ctl,
    input  logic [bcd_pkg::RING_CFG_W-1:0]    ring_frames,
    input  logic [bcd_pkg::PERIOD_CFG_W-1:0]  period_frames,
    output bcd_pkg::frame_info_t              info
);
    import bcd_pkg::*;

    localparam int MAX_W  = $clog2(MAX_RING_FRAMES + 1);
    localparam int RCMP_W = (MAX_W > RING_CFG_W) ? MAX_W : RING_CFG_W;

    logic [RING_POS_W-1:0]   wp_reg;
    logic [RING_POS_W-1:0]   wp_next;
    logic [PERIOD_CNT_W-1:0] period_cnt_reg;
    logic [PERIOD_CNT_W-1:0] period_cnt_next;
    logic [RCMP_W-1:0]       ring_sat;
    logic [RCMP_W-1:0]       wp_inc;
    logic [PERIOD_CFG_W-1:0] period_sat;
    logic [PERIOD_CFG_W-1:0] period_inc;

    assign ring_sat = (RCMP_W'(ring_frames) > RCMP_W'(MAX_RING_FRAMES))
                    ? RCMP_W'(MAX_RING_FRAMES) : RCMP_W'(ring_frames);
    assign wp_inc   = RCMP_W'(wp_reg) + RCMP_W'(1);

    assign period_sat = (period_frames > PERIOD_CFG_W'(PERIOD_MAX))
                      ? PERIOD_CFG_W'(PERIOD_MAX) : period_frames;
    assign period_inc = PERIOD_CFG_W'(period_cnt_reg) + PERIOD_CFG_W'(1);

    assign info.ring_position = wp_reg;
    assign info.period_done   = (period_inc >= period_sat);

    always_comb begin
        wp_next         = wp_reg;
        period_cnt_next = period_cnt_reg;
        if (ctl.restart) begin
            wp_next         = '0;
            period_cnt_next = '0;
        end else if (ctl.frame_end) begin
            wp_next         = (wp_inc >= ring_sat) ? '0 : wp_inc[RING_POS_W-1:0];
            period_cnt_next = info.period_done ? '0 : period_inc[PERIOD_CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg         <= '0;
            period_cnt_reg <= '0;
        end else begin
            wp_reg         <= wp_next;
            period_cnt_reg <= period_cnt_next;
        end
    end

endmodule

// ===== hdl/bcd_drain.sv =====
module bcd_drain #(
    parameter int CHANNELS    = bcd_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS = bcd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  bcd_pkg::frame_info_t   info,
    input  logic [SAMPLE_BITS-1:0] shift_next [CHANNELS],
    output logic                   busy,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bcd_pkg::out_item_t     m_data
);
    import bcd_pkg::*;

    localparam int CNT_W = $clog2(CHANNELS + 1);

    logic [SAMPLE_BITS-1:0] bank_reg [CHANNELS];
    logic [CNT_W-1:0]       remain_reg;
    logic [CNT_W-1:0]       remain_next;
    frame_info_t            info_reg;
    logic                   pop;

    assign busy    = (remain_reg != '0);
    assign m_valid = busy;
    assign pop     = m_valid && m_ready;

    assign m_data.sample        = SAMPLE_W'(bank_reg[0]) << SAMPLE_SHIFT;
    assign m_data.channel       = CHANNEL_W'(CNT_W'(CHANNELS) - remain_reg);
    assign m_data.ring_position = info_reg.ring_position;
    assign m_data.period_done   = info_reg.period_done;
    assign m_data.last          = (remain_reg == CNT_W'(1));

    always_comb begin
        if (load) begin
            remain_next = CNT_W'(CHANNELS);
        end else if (pop) begin
            remain_next = remain_reg - CNT_W'(1);
        end else begin
            remain_next = remain_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg <= '0;
        end else begin
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            info_reg <= info;
        end
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_bank
        always_ff @(posedge aclk) begin
            if (load) begin
                bank_reg[c] <= shift_next[c];
            end else if (pop) begin
                bank_reg[c] <= (c == CHANNELS - 1) ? '0 : bank_reg[(c + 1) % CHANNELS];
            end
        end
    end

endmodule

// ===== hdl/bitplane_capture_deinterleaver.sv =====
// Channel  Ports                               Carries
// s_       s_valid s_ready s_data (in_item_t)   action, data_byte
// m_       m_valid m_ready m_data (out_item_t)  sample, channel, ring_position, ...
// cfg_     cfg_wr_en cfg_index cfg_wr_data      capture_enable, ring_frames, period_frames
//
// One input item per cycle while s_ready is high. The last byte of a frame loads
// CHANNELS samples into a snapshot bank that drains one result per cycle while
// m_ready is high, so a frame of FRAME_BYTES bytes then sustains one byte per cycle.
// The last byte of a frame is held off only while the bank still drains.
// Reset is synchronous; no clearing pass.
module bitplane_capture_deinterleaver #(
    parameter int CHANNELS        = bcd_pkg::DEF_CHANNELS,
    parameter int SAMPLE_BITS     = bcd_pkg::DEF_SAMPLE_BITS,
    parameter int FRAME_BYTES     = bcd_pkg::DEF_FRAME_BYTES,
    parameter int MAX_RING_FRAMES = bcd_pkg::DEF_MAX_RING_FRAMES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bcd_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bcd_pkg::out_item_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [bcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bcd_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import bcd_pkg::*;

    logic                    capture_enable_reg;
    logic [RING_CFG_W-1:0]   ring_frames_reg;
    logic [PERIOD_CFG_W-1:0] period_frames_reg;
    logic                    s_accept;
    logic                    last_byte;
    logic                    busy;
    ctl_t                    ctl;
    frame_info_t             info;
    logic [SAMPLE_BITS-1:0]  shift_next [CHANNELS];

    assign s_ready  = !(capture_enable_reg && last_byte && busy);
    assign s_accept = s_valid && s_ready;

    assign ctl.restart   = s_accept && (s_data.action == ACT_RESTART);
    assign ctl.shift     = s_accept && (s_data.action == ACT_DATA) && capture_enable_reg;
    assign ctl.frame_end = ctl.shift && last_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_enable_reg <= 1'b0;
            ring_frames_reg    <= RING_CFG_W'(16384);
            period_frames_reg  <= PERIOD_CFG_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CAPTURE_ENABLE: capture_enable_reg <= cfg_wr_data[0];
                CFG_RING_FRAMES:    ring_frames_reg    <= cfg_wr_data[RING_CFG_W-1:0];
                CFG_PERIOD_FRAMES:  period_frames_reg  <= cfg_wr_data[PERIOD_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bcd_shift #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_shift (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .data_byte  (s_data.data_byte),
        .last_byte  (last_byte),
        .shift_next (shift_next)
    );

    bcd_frame #(
        .MAX_RING_FRAMES (MAX_RING_FRAMES)
    ) u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .ring_frames   (ring_frames_reg),
        .period_frames (period_frames_reg),
        .info          (info)
    );

    bcd_drain #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_drain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (ctl.frame_end),
        .info       (info),
        .shift_next (shift_next),
        .busy       (busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bcd_pkg::*;

    localparam int FRAME_B     = DEF_FRAME_BYTES;
    localparam int HALF_B      = DEF_FRAME_BYTES / 2;
    localparam int PLANES      = DEF_SAMPLE_BITS;
    localparam int RAND_ITEMS  = 180;
    localparam int SETTLE_GAP  = 8;
    localparam int DRAIN_TAIL  = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [SAMPLE_W-1:0] S_ONES = 32'hFFFF_FF00;
    localparam logic [SAMPLE_W-1:0] S_ZERO = 32'h0000_0000;

    typedef enum logic [2:0] {
        ROW_CFG,
        ROW_RESTART,
        ROW_NOISE,
        ROW_FRAME
    } row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [15:0]           val;
        logic [7:0]            fill_even;
        logic [7:0]            fill_odd;
        logic [7:0]            count;
        logic                  typed;
        logic [SAMPLE_W-1:0]   exp_even;
        logic [SAMPLE_W-1:0]   exp_odd;
    } plan_row_t;

    localparam int PLAN_ROWS = 14;
    plan_row_t plan [0:PLAN_ROWS-1] = '{
        '{ROW_NOISE,   CFG_SPARE,          16'd0,     8'h00, 8'h00, 8'd6,  1'b0, S_ZERO, S_ZERO},
        '{ROW_CFG,     CFG_CAPTURE_ENABLE, 16'd1,     8'h00, 8'h00, 8'd0,  1'b0, S_ZERO, S_ZERO},
        '{ROW_FRAME,   CFG_SPARE,          16'd0,     8'hFF, 8'h00, 8'd1,  1'b1, S_ONES, S_ZERO},
        '{ROW_FRAME,   CFG_SPARE,          16'd0,     8'h00, 8'hFF, 8'd1,  1'b1, S_ZERO, S_ONES},
        '{ROW_CFG,     CFG_RING_FRAMES,    16'd0,     8'h00, 8'h00, 8'd0,  1'b0, S_ZERO, S_ZERO},
        '{ROW_CFG,     CFG_PERIOD_FRAMES,  16'd0,     8'h00, 8'h00, 8'd0,  1'b0, S_ZERO, S_ZERO},
        '{ROW_FRAME,   CFG_SPARE,          16'd0,     8'hFF, 8'hFF, 8'd1,  1'b1, S_ONES, S_ONES},
        '{ROW_NOISE,   CFG_SPARE,          16'd0,     8'h00, 8'h00, 8'd30, 1'b0, S_ZERO, S_ZERO},
        '{ROW_RESTART, CFG_SPARE,          16'd0,     8'hFF, 8'h00, 8'd1,  1'b0, S_ZERO, S_ZERO},
        '{ROW_CFG,     CFG_CAPTURE_ENABLE, 16'd0,     8'h00, 8'h00, 8'd0,  1'b0, S_ZERO, S_ZERO},
        '{ROW_NOISE,   CFG_SPARE,          16'd0,     8'h00, 8'h00, 8'd5,  1'b0, S_ZERO, S_ZERO},
        '{ROW_RESTART, CFG_SPARE,          16'd0,     8'h00, 8'h00, 8'd1,  1'b0, S_ZERO, S_ZERO},
        '{ROW_CFG,     CFG_SPARE,          16'h7FFF,  8'h00, 8'h00, 8'd0,  1'b0, S_ZERO, S_ZERO},
        '{ROW_CFG,     CFG_CAPTURE_ENABLE, 16'd1,     8'h00, 8'h00, 8'd0,  1'b0, S_ZERO, S_ZERO}
    };

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // shadow of the block's state and registers
    logic [PLANES-1:0] chan_sr [DEF_CHANNELS];
    logic [5:0] byte_pos = '0;
    logic [RING_POS_W-1:0] wr_pos = '0;
    logic [PERIOD_CNT_W-1:0] per_cnt = '0;
    logic cap_en = 1'b0;
    logic [RING_CFG_W-1:0] ring_cfg = RING_CFG_W'(DEF_MAX_RING_FRAMES);
    logic [PERIOD_CFG_W-1:0] per_cfg = PERIOD_CFG_W'(256);

    logic typed_on = 1'b0;
    logic [SAMPLE_W-1:0] typed_even = '0;
    logic [SAMPLE_W-1:0] typed_odd = '0;

    out_item_t pending_samples [$];
    int errors = 0;
    int results_checked = 0;
    int frames_done = 0;
    int restarts_seen = 0;
    int bytes_dropped = 0;
    int burst_left = 0;
    int holds_done = 0;
    int cycle_cnt = 0;
    logic hold_req = 1'b0;

    bitplane_capture_deinterleaver DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void shift_plane(input int first, input logic [7:0] b);
        for (int n = 0; n < 8; n++) begin
            chan_sr[first + 2 * n] = {chan_sr[first + 2 * n][PLANES-2:0], b[n]};
        end
    endfunction

    function automatic void track_item(input in_item_t it);
        int per_lim;
        int ring_lim;
        int nxt;
        logic done;
        out_item_t r;
        if (it.action == ACT_RESTART) begin
            foreach (chan_sr[c]) chan_sr[c] = '0;
            byte_pos = '0;
            wr_pos = '0;
            per_cnt = '0;
            restarts_seen++;
            return;
        end
        if (!cap_en) begin
            bytes_dropped++;
            return;
        end
        if (byte_pos < PLANES) begin
            shift_plane(0, it.data_byte);
        end else if (byte_pos >= HALF_B && byte_pos < HALF_B + PLANES) begin
            shift_plane(1, it.data_byte);
        end
        if (int'(byte_pos) + 1 < FRAME_B) begin
            byte_pos = byte_pos + 1'b1;
            return;
        end
        byte_pos = '0;
        per_lim = (int'(per_cfg) > PERIOD_MAX) ? PERIOD_MAX : int'(per_cfg);
        if (int'(per_cnt) + 1 >= per_lim) begin
            done = 1'b1;
            per_cnt = '0;
        end else begin
            done = 1'b0;
            per_cnt = per_cnt + 1'b1;
        end
        for (int c = 0; c < DEF_CHANNELS; c++) begin
            r.sample = SAMPLE_W'(chan_sr[c]) << SAMPLE_SHIFT;
            if (typed_on) r.sample = (c % 2 == 0) ? typed_even : typed_odd;
            r.channel = CHANNEL_W'(c);
            r.ring_position = wr_pos;
            r.period_done = done;
            r.last = (c == DEF_CHANNELS - 1);
            pending_samples.push_back(r);
        end
        ring_lim = (int'(ring_cfg) > DEF_MAX_RING_FRAMES) ? DEF_MAX_RING_FRAMES : int'(ring_cfg);
        nxt = int'(wr_pos) + 1;
        if (nxt >= ring_lim) nxt = 0;
        wr_pos = RING_POS_W'(nxt);
        frames_done++;
    endfunction

    function automatic void field_err(input string name, input longint want, input longint got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) track_item(s_data);
            if (m_valid && m_ready) begin
                if (pending_samples.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: result with nothing expected, expected none, got %p",
                                 $time, m_data);
                    end
                end else begin
                    want = pending_samples.pop_front();
                    results_checked++;
                    if (m_data.sample !== want.sample)
                        field_err("sample", want.sample, m_data.sample);
                    if (m_data.channel !== want.channel)
                        field_err("channel", want.channel, m_data.channel);
                    if (m_data.ring_position !== want.ring_position)
                        field_err("ring_position", want.ring_position, m_data.ring_position);
                    if (m_data.period_done !== want.period_done)
                        field_err("period_done", want.period_done, m_data.period_done);
                    if (m_data.last !== want.last)
                        field_err("last", want.last, m_data.last);
                end
            end
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        int mode;
        int left;
        int hold;
        int tick;
        mode = 0;
        left = 0;
        hold = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold = HOLD_CYCLES;
                holds_done++;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 120);
                end
                left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (tick % 5 != 0);
                endcase
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_cnt, pending_samples.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic push_item(input logic act, input logic [7:0] b);
        int gap;
        in_item_t it;
        it.action = act;
        it.data_byte = b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge aclk);
        repeat (SETTLE_GAP) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_CAPTURE_ENABLE: cap_en = val[0];
            CFG_RING_FRAMES:    ring_cfg = RING_CFG_W'(val);
            CFG_PERIOD_FRAMES:  per_cfg = PERIOD_CFG_W'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        plan_row_t row;
        logic [7:0] b;
        int rand_items;
        int phase;
        int nfr;
        int ring_pick;
        int per_pick;
        logic en_pick;
        logic squeeze;
        foreach (chan_sr[c]) chan_sr[c] = '0;
        rand_items = 0;
        phase = 0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = plan[i];
            case (row.kind)
                ROW_CFG: begin
                    settle();
                    write_reg(row.idx, row.val);
                end
                ROW_RESTART: push_item(ACT_RESTART, row.fill_even);
                ROW_NOISE: repeat (row.count) push_item(ACT_DATA, 8'($urandom_range(0, 255)));
                default: begin
                    repeat (row.count) begin
                        typed_on = row.typed;
                        typed_even = row.exp_even;
                        typed_odd = row.exp_odd;
                        for (int k = 0; k < FRAME_B; k++) begin
                            b = 8'($urandom_range(0, 255));
                            if (row.kind == ROW_FRAME) begin
                                if (k < PLANES) b = row.fill_even;
                                else if (k >= HALF_B && k < HALF_B + PLANES) b = row.fill_odd;
                            end
                            push_item(ACT_DATA, b);
                        end
                        typed_on = 1'b0;
                    end
                end
            endcase
        end

        while (rand_items < RAND_ITEMS) begin
            settle();
            squeeze = (phase == 0);
            case ($urandom_range(0, 9))
                0: ring_pick = 0;
                1: ring_pick = 24;
                2: ring_pick = DEF_MAX_RING_FRAMES;
                3: ring_pick = $urandom_range(DEF_MAX_RING_FRAMES + 1, 32767);
                4: ring_pick = $urandom_range(0, 32767);
                default: ring_pick = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 9))
                0: per_pick = 0;
                1: per_pick = 12;
                2: per_pick = PERIOD_MAX;
                3: per_pick = $urandom_range(PERIOD_MAX + 1, 16383);
                4: per_pick = $urandom_range(0, 16383);
                default: per_pick = $urandom_range(1, 4);
            endcase
            en_pick = squeeze || ($urandom_range(0, 7) != 0);
            write_reg(CFG_RING_FRAMES, ring_pick);
            write_reg(CFG_PERIOD_FRAMES, per_pick);
            write_reg(CFG_CAPTURE_ENABLE, en_pick);
            if (!en_pick) begin
                repeat ($urandom_range(10, 30)) push_item(ACT_DATA, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) begin
                    push_item(ACT_RESTART, 8'($urandom_range(0, 255)));
                    rand_items++;
                end
            end else begin
                nfr = squeeze ? 2 : 1;
                if (squeeze) hold_req = 1'b1;
                repeat (nfr * FRAME_B) begin
                    if (!squeeze && $urandom_range(0, 99) < 2) begin
                        push_item(ACT_RESTART, 8'($urandom_range(0, 255)));
                        rand_items++;
                    end
                    push_item(ACT_DATA, 8'($urandom_range(0, 255)));
                    rand_items++;
                end
            end
            phase++;
        end

        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge aclk);
        repeat (DRAIN_TAIL) @(negedge aclk);

        $display("Compared %0d channel samples over %0d frames in %0d random phases.",
                 results_checked, frames_done, phase);
        $display("Restarts: %0d, bytes dropped while disabled: %0d, long output holds: %0d.",
                 restarts_seen, bytes_dropped, holds_done);
        if (errors == 0 && pending_samples.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
